/* design/qei_pkg.sv */
// qei_pkg: shared types and constants for the quaternion Euler integrator.
// Used by qei_ctrl, qei_dp and quaternion_euler_integrator_core. No dependencies.
package qei_pkg;

	localparam int QW = 32;                 // attitude component width, Q2.30
	localparam int TW = 32;                 // timestamp width
	localparam int RW = 32;                 // rate width, Q8.24
	localparam int DW = 59;                 // dt width, Q.32 seconds, capped at 2^26 s

	localparam logic [31:0] TICK_RESET = 32'd4295;

	localparam int SHIFT_STEPS = 29;        // normalising shifts, enough for any non-zero max
	localparam int ROOT_STEPS  = 32;        // one result bit per step
	localparam int DIV_STEPS   = 32;        // after the leading quotient bit

	typedef enum logic [2:0] {
		ST_INTEG = 3'd0,
		ST_FIRST = 3'd1,
		ST_SKIP  = 3'd2,
		ST_ZERO  = 3'd3,
		ST_SET   = 3'd4
	} status_t;

	typedef struct packed {
		logic                 func;
		logic [TW-1:0]        timestamp;
		logic signed [RW-1:0] rate_w;
		logic signed [RW-1:0] rate_x;
		logic signed [RW-1:0] rate_y;
		logic signed [RW-1:0] rate_z;
		logic signed [QW-1:0] att_w;
		logic signed [QW-1:0] att_x;
		logic signed [QW-1:0] att_y;
		logic signed [QW-1:0] att_z;
	} in_item_t;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic [2:0]           status;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_SET,
		OP_FIRST,
		OP_SKIP,
		OP_MULD,
		OP_CAPD,
		OP_MULA,
		OP_MULB,
		OP_ACC,
		OP_MAG,
		OP_IDENT,
		OP_SHIFT,
		OP_SQ,
		OP_SQACC,
		OP_SQRTI,
		OP_SQRTS,
		OP_DIVI,
		OP_DIVS,
		OP_DIVD,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
		status_t    status;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic seen;
		logic skip;
		logic zero;
	} dp_stat_t;

endpackage

/* design/qei_dp.sv */
// qei_dp: datapath of the integrator: state, shared multiplier, root and divider.
// Depends on qei_pkg; driven one command per cycle by qei_ctrl.
module qei_dp import qei_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  in_item_t  in_data,
	input  logic      cfg_we,
	input  logic [31:0] cfg_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_item_t out_data
);

	localparam logic [63:0] DLIM = 64'd1 << 58;
	localparam logic [38:0] ICAP = 39'd1 << 33;
	localparam logic signed [34:0] QLO = -(35'sd1 <<< (QW - 1));
	localparam logic signed [34:0] QHI = (35'sd1 <<< (QW - 1)) - 35'sd1;

	logic [31:0]           tick_q;
	logic signed [QW-1:0]  att_q [4];
	logic [TW-1:0]         last_q;
	logic                  seen_q;

	logic                  func_q;
	logic [TW-1:0]         ts_q;
	logic signed [RW-1:0]  rate_q [4];
	logic signed [QW-1:0]  atin_q [4];

	logic [DW-1:0]         d_q;
	logic [63:0]           prod_q;
	logic [57:0]           a_q;
	logic [31:0]           mag_q [4];
	logic [3:0]            neg_q;
	logic [31:0]           mx_q;
	logic [61:0]           s2_q;
	logic [62:0]           sv_q, sr_q, sb_q;
	logic [31:0]           rem_q;
	logic [32:0]           quo_q;
	out_item_t             out_q;

	logic [TW-1:0]         diff;
	logic [31:0]           rmag, mul_a, mul_b;
	logic [31:0]           amag [4];
	logic [31:0]           mx01, mx23, mxall;
	logic [38:0]           isum;
	logic [33:0]           inc;
	logic signed [34:0]    accv;
	logic signed [QW-1:0]  accq;
	logic [62:0]           rtry;
	logic [31:0]           nroot, dmag;
	logic [32:0]           dsh;
	logic                  dge0, dge;
	logic [QW-1:0]         ratio;

	assign diff = ts_q - last_q;
	assign stat.func = func_q;
	assign stat.seen = seen_q;
	assign stat.skip = (diff == '0) || diff[TW-1] || (tick_q == '0);
	assign stat.zero = (mx_q == '0);
	assign out_data  = out_q;

	always_comb begin
		rmag = rate_q[cmd.idx][RW-1] ? 32'(-rate_q[cmd.idx]) : 32'(rate_q[cmd.idx]);
		for (int i = 0; i < 4; i++)
			amag[i] = att_q[i][QW-1] ? 32'(-att_q[i]) : 32'(att_q[i]);
		mx01  = (amag[1] > amag[0]) ? amag[1] : amag[0];
		mx23  = (amag[3] > amag[2]) ? amag[3] : amag[2];
		mxall = (mx23 > mx01) ? mx23 : mx01;
		case (cmd.op)
			OP_MULD: begin
				mul_a = 32'(diff);
				mul_b = tick_q;
			end
			OP_MULA: begin
				mul_a = rmag;
				mul_b = 32'(d_q[DW-1:32]);
			end
			OP_MULB: begin
				mul_a = rmag;
				mul_b = d_q[31:0];
			end
			default: begin
				mul_a = mag_q[cmd.idx];
				mul_b = mag_q[cmd.idx];
			end
		endcase
		// increment = floor(|rate| * dt / 2^26), capped at 2^33
		isum = 39'({a_q[26:0], 6'b0}) + 39'(prod_q[63:26]);
		if (a_q[57:27] != '0 || isum > ICAP)
			inc = ICAP[33:0];
		else
			inc = isum[33:0];
		accv = rate_q[cmd.idx][RW-1]
			? 35'(att_q[cmd.idx]) - $signed({1'b0, inc})
			: 35'(att_q[cmd.idx]) + $signed({1'b0, inc});
		if (accv < QLO)
			accq = QLO[QW-1:0];
		else if (accv > QHI)
			accq = QHI[QW-1:0];
		else
			accq = accv[QW-1:0];
		rtry  = sr_q + sb_q;
		nroot = sr_q[31:0];
		dmag  = mag_q[cmd.idx];
		dge0  = dmag >= nroot;
		dsh   = {rem_q, 1'b0};
		dge   = dsh >= {1'b0, nroot};
		ratio = QW'(quo_q >> 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= TICK_RESET;
			att_q[0] <= QW'(1) << (QW - 2);
			att_q[1] <= '0;
			att_q[2] <= '0;
			att_q[3] <= '0;
			last_q   <= '0;
			seen_q   <= 1'b0;
		end else begin
			if (cfg_we)
				tick_q <= cfg_data;
			case (cmd.op)
				OP_SET: begin
					for (int i = 0; i < 4; i++)
						att_q[i] <= atin_q[i];
				end
				OP_FIRST: begin
					last_q <= ts_q;
					seen_q <= 1'b1;
				end
				OP_SKIP, OP_CAPD: last_q <= ts_q;
				OP_ACC: att_q[cmd.idx] <= accq;
				OP_IDENT: begin
					att_q[0] <= QW'(1) << (QW - 2);
					att_q[1] <= '0;
					att_q[2] <= '0;
					att_q[3] <= '0;
				end
				OP_DIVD: att_q[cmd.idx] <= neg_q[cmd.idx] ? -$signed(ratio) : $signed(ratio);
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			func_q    <= in_data.func;
			ts_q      <= in_data.timestamp;
			rate_q[0] <= in_data.rate_w;
			rate_q[1] <= in_data.rate_x;
			rate_q[2] <= in_data.rate_y;
			rate_q[3] <= in_data.rate_z;
			atin_q[0] <= in_data.att_w;
			atin_q[1] <= in_data.att_x;
			atin_q[2] <= in_data.att_y;
			atin_q[3] <= in_data.att_z;
		end
		case (cmd.op)
			OP_MULD, OP_MULA, OP_SQ: prod_q <= 64'(mul_a) * 64'(mul_b);
			OP_MULB: begin
				prod_q <= 64'(mul_a) * 64'(mul_b);
				a_q    <= prod_q[57:0];
			end
			OP_CAPD: d_q <= (prod_q > DLIM) ? DLIM[DW-1:0] : prod_q[DW-1:0];
			OP_MAG: begin
				for (int i = 0; i < 4; i++) begin
					mag_q[i] <= amag[i];
					neg_q[i] <= att_q[i][QW-1];
				end
				mx_q <= mxall;
				s2_q <= '0;
			end
			OP_SHIFT: begin
				if (mx_q >= 32'h4000_0000) begin
					for (int i = 0; i < 4; i++)
						mag_q[i] <= mag_q[i] >> 1;
					mx_q <= mx_q >> 1;
				end else if (mx_q < 32'h2000_0000) begin
					for (int i = 0; i < 4; i++)
						mag_q[i] <= mag_q[i] << 1;
					mx_q <= mx_q << 1;
				end
			end
			OP_SQACC: s2_q <= s2_q + prod_q[61:0];
			OP_SQRTI: begin
				sv_q <= 63'(s2_q);
				sr_q <= '0;
				sb_q <= 63'd1 << 62;
			end
			OP_SQRTS: begin
				if (sv_q >= rtry) begin
					sv_q <= sv_q - rtry;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			OP_DIVI: begin
				rem_q <= dge0 ? dmag - nroot : dmag;
				quo_q <= 33'(dge0);
			end
			OP_DIVS: begin
				rem_q <= dge ? 32'(dsh - {1'b0, nroot}) : dsh[31:0];
				quo_q <= {quo_q[31:0], dge};
			end
			OP_OUT: begin
				out_q.quat_w <= att_q[0];
				out_q.quat_x <= att_q[1];
				out_q.quat_y <= att_q[2];
				out_q.quat_z <= att_q[3];
				out_q.status <= cmd.status;
			end
			default: ;
		endcase
	end

endmodule

/* design/qei_ctrl.sv */
// qei_ctrl: sequencer that issues one datapath command per cycle per item.
// Depends on qei_pkg; holds the handshake state of both channels.
module qei_ctrl import qei_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_acc,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     in_ready,
	output logic     out_valid
);

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_CAPD, S_MULA, S_MULB, S_ACC, S_MAG, S_ZWAIT, S_ZCHK,
		S_SHIFT, S_SQ, S_SQACC, S_SQRTI, S_SQRT, S_DIVI, S_DIV, S_DIVD, S_FIN, S_EMIT
	} state_t;

	state_t     state_q;
	dp_cmd_t    cmd_q;
	status_t    st_q;
	logic [1:0] idx_q;
	logic [4:0] cnt_q;
	logic       rdy_q, ov_q;

	assign cmd       = cmd_q;
	assign in_ready  = rdy_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin : p_seq
		dp_op_t op_n;
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '{op: OP_NOP, idx: 2'd0, status: ST_INTEG};
			st_q    <= ST_INTEG;
			idx_q   <= '0;
			cnt_q   <= '0;
			rdy_q   <= 1'b1;
			ov_q    <= 1'b0;
		end else begin
			op_n = OP_NOP;
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rdy_q   <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (stat.func) begin
						op_n    = OP_SET;
						st_q    <= ST_SET;
						state_q <= S_FIN;
					end else if (!stat.seen) begin
						op_n    = OP_FIRST;
						st_q    <= ST_FIRST;
						state_q <= S_FIN;
					end else if (stat.skip) begin
						op_n    = OP_SKIP;
						st_q    <= ST_SKIP;
						state_q <= S_FIN;
					end else begin
						op_n    = OP_MULD;
						state_q <= S_CAPD;
					end
				end
				S_CAPD: begin
					op_n    = OP_CAPD;
					idx_q   <= '0;
					state_q <= S_MULA;
				end
				S_MULA: begin
					op_n    = OP_MULA;
					state_q <= S_MULB;
				end
				S_MULB: begin
					op_n    = OP_MULB;
					state_q <= S_ACC;
				end
				S_ACC: begin
					op_n    = OP_ACC;
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd3) ? S_MAG : S_MULA;
				end
				S_MAG: begin
					op_n    = OP_MAG;
					state_q <= S_ZWAIT;
				end
				S_ZWAIT: state_q <= S_ZCHK;
				S_ZCHK: begin
					if (stat.zero) begin
						op_n    = OP_IDENT;
						st_q    <= ST_ZERO;
						state_q <= S_FIN;
					end else begin
						op_n    = OP_SHIFT;
						cnt_q   <= '0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					op_n  = OP_SHIFT;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SHIFT_STEPS - 2))
						state_q <= S_SQ;
				end
				S_SQ: begin
					op_n    = OP_SQ;
					state_q <= S_SQACC;
				end
				S_SQACC: begin
					op_n    = OP_SQACC;
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd3) ? S_SQRTI : S_SQ;
				end
				S_SQRTI: begin
					op_n    = OP_SQRTI;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					op_n  = OP_SQRTS;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ROOT_STEPS - 1))
						state_q <= S_DIVI;
				end
				S_DIVI: begin
					op_n    = OP_DIVI;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					op_n  = OP_DIVS;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1))
						state_q <= S_DIVD;
				end
				S_DIVD: begin
					op_n  = OP_DIVD;
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						st_q    <= ST_INTEG;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIVI;
					end
				end
				S_FIN: begin
					if (!ov_q || out_ready) begin
						op_n    = OP_OUT;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					ov_q    <= 1'b1;
					rdy_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			cmd_q <= '{op: op_n, idx: idx_q, status: st_q};
		end
	end

	a_acc_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !rdy_q) else $error("ready held after accept");
	a_idle_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> (cmd_q.op == OP_NOP)) else $error("command issued while idle");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |=> ov_q) else $error("result beat not presented");
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && ov_q && !out_ready) |=> (state_q == S_FIN))
		else $error("result overwritten before taken");

endmodule

/* design/quaternion_euler_integrator_core.sv */
// quaternion_euler_integrator_core: top level of the attitude integrator.
// Depends on qei_pkg, qei_ctrl and qei_dp.
//
// Keeps a Q2.30 attitude quaternion (identity after reset) and returns one result
// beat per input beat. An integrate beat forms dt from the tick difference and the
// tick period register, adds rate * dt to each component with saturation and
// renormalises, or returns the identity if all components end up zero; set beats
// load the attitude as given. One item is worked on at a time: set, first-time and
// skipped beats go from the decide state straight to the finish and emit states;
// an integrating beat passes through 29 normalising shift steps, the 32-step
// square root and the four 33-step radix-2 divisions that follow it, and makes 13
// passes through the one 32x32 multiplier. in_ready drops at accept and returns
// with out_valid, so no new beat is taken while one is in work. The finished
// result sits in an output register, so a result not yet taken never blocks
// acceptance of the next beat; only its own completion waits for the register to
// free. The tick period write port is always ready; write it only while the block
// is idle.
module quaternion_euler_integrator_core import qei_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic     in_acc;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// item beat taken into the datapath input registers at this edge
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	qei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	qei_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_acc),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

/* bench/quaternion_euler_integrator_core_tb.sv */
// quaternion_euler_integrator_core_tb: self-checking bench for the attitude integrator.
// Depends on qei_pkg and quaternion_euler_integrator_core; predicts each result in-bench.
`timescale 1ns / 1ps

module quaternion_euler_integrator_core_tb;
	import qei_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [31:0] cfg_data;

	quaternion_euler_integrator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Predictor state, kept alongside the block.
	logic [31:0]        tick_period;
	logic signed [63:0] att [4];
	logic [31:0]        prev_stamp;
	logic               stamp_seen;

	out_item_t expected_q [$];
	int        error_count;
	int        send_idle_pct;     // sender gap chance, percent
	int        recv_idle_pct;     // receiver stall chance, percent
	bit        hold_off;          // long receiver stall in progress
	logic [31:0] stamp_now;       // running timestamp for random beats

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(m*d / 2^26), capped at 2^33; d is dt in Q.32 seconds
	function automatic logic [63:0] step_increment(input logic [63:0] m, input logic [63:0] d);
		logic [63:0] hi_part, lo_part, r;
		hi_part = m * (d >> 32);
		lo_part = m * (d & 64'hFFFF_FFFF);
		if ((hi_part >> 27) != 0) return 64'd1 << 33;
		r = (hi_part << 6) + (lo_part >> 26);
		return (r > (64'd1 << 33)) ? (64'd1 << 33) : r;
	endfunction

	function automatic status_t renormalise();
		logic [63:0] mag [4];
		logic [63:0] mx, sumsq, root, ratio;
		int bl;
		mx = 0;
		sumsq = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = att[i] < 0 ? -att[i] : att[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			att[0] = 64'sd1 << 30;
			att[1] = 0; att[2] = 0; att[3] = 0;
			return ST_ZERO;
		end
		bl = 0;
		while (bl < 64 && (mx >> bl) != 0) bl++;
		for (int i = 0; i < 4; i++) begin
			mag[i] = bl > 30 ? mag[i] >> (bl - 30) : mag[i] << (30 - bl);
			sumsq += mag[i] * mag[i];
		end
		root = isqrt(sumsq);
		for (int i = 0; i < 4; i++) begin
			ratio = ((mag[i] << 32) / root) >> 2;
			if (ratio > 64'h7FFF_FFFF) ratio = 64'h7FFF_FFFF;
			att[i] = att[i] < 0 ? -$signed(ratio) : $signed(ratio);
		end
		return ST_INTEG;
	endfunction

	function automatic out_item_t predict_attitude(input in_item_t it);
		out_item_t   res;
		status_t     st;
		logic [31:0] diff;
		logic [63:0] dt, m, inc;
		logic signed [63:0] r, v;
		logic signed [31:0] rates [4];
		rates = '{it.rate_w, it.rate_x, it.rate_y, it.rate_z};
		if (it.func) begin
			att[0] = it.att_w; att[1] = it.att_x; att[2] = it.att_y; att[3] = it.att_z;
			st = ST_SET;
		end else if (!stamp_seen) begin
			prev_stamp = it.timestamp;
			stamp_seen = 1'b1;
			st = ST_FIRST;
		end else begin
			diff = it.timestamp - prev_stamp;
			prev_stamp = it.timestamp;
			if (diff == 0 || diff[31] || tick_period == 0) begin
				st = ST_SKIP;
			end else begin
				if (64'(diff) > (64'd1 << 58) / tick_period) dt = 64'd1 << 58;
				else dt = 64'(diff) * tick_period;
				for (int i = 0; i < 4; i++) begin
					r = rates[i];
					m = r < 0 ? -r : r;
					inc = step_increment(m, dt);
					v = att[i] + (r < 0 ? -$signed(inc) : $signed(inc));
					if (v < -(64'sd1 << 31)) v = -(64'sd1 << 31);
					if (v > (64'sd1 << 31) - 1) v = (64'sd1 << 31) - 1;
					att[i] = v;
				end
				st = renormalise();
			end
		end
		res.quat_w = att[0][31:0];
		res.quat_x = att[1][31:0];
		res.quat_y = att[2][31:0];
		res.quat_z = att[3][31:0];
		res.status = st;
		return res;
	endfunction

	// One input beat: random gap, then hold valid until accepted. Valid stays up
	// after the accept edge so the next beat can follow straight on; drain drops it.
	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(predict_attitude(it));
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// an accepted beat may still be in flight, let the longest pass finish
		repeat (300) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_tick(input logic [31:0] period);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= period;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tick_period = period;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t integ_beat(input logic [31:0] ts, input logic [31:0] rw,
			input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz);
		in_item_t it;
		it = '{default: '0};
		it.att_w = $urandom; it.att_x = $urandom;   // ignored fields still toggle
		it.att_y = $urandom; it.att_z = $urandom;
		it.timestamp = ts;
		it.rate_w = rw; it.rate_x = rx; it.rate_y = ry; it.rate_z = rz;
		return it;
	endfunction

	function automatic in_item_t set_beat(input logic [31:0] w, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		in_item_t it;
		it = '{default: '0};
		it.func = 1'b1;
		it.timestamp = $urandom;
		it.rate_w = $urandom; it.rate_x = $urandom;
		it.rate_y = $urandom; it.rate_z = $urandom;
		it.att_w = w; it.att_x = x; it.att_y = y; it.att_z = z;
		return it;
	endfunction

	// Directed: first sample, skips, saturation, zero norm, set extremes.
	task automatic test_directed();
		send_item(integ_beat(32'd1000, 32'h0100_0000, 0, 0, 0));           // first time only
		send_item(integ_beat(32'd2000, 32'h0100_0000, 32'h0080_0000, 0, 0));
		send_item(integ_beat(32'd2000, 32'h0100_0000, 0, 0, 0));           // zero diff
		send_item(integ_beat(32'd1500, 32'h0100_0000, 0, 0, 0));           // negative diff
		send_item(integ_beat(32'h8000_05DC, 32'h7FFF_FFFF, 0, 0, 0));      // wrap to negative
		send_item(integ_beat(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF));                                 // huge dt, saturate
		send_item(integ_beat(32'h0000_0010, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1));
		send_item(set_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_item(set_beat(0, 0, 0, 0));
		send_item(integ_beat(32'h0000_0020, 0, 0, 0, 0));                  // zero norm to identity
		send_item(set_beat(32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
		send_item(integ_beat(32'h0000_0030, 1, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF));
		send_item(set_beat(32'h0000_0001, 0, 0, 0));                      // tiny magnitude
		send_item(integ_beat(32'h0000_0031, 0, 0, 0, 0));
		send_item(set_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_item(integ_beat(32'h0000_0032, 0, 0, 0, 0));
		stamp_now = 32'h0000_0032;
	endtask

	task automatic test_tick_period();
		write_tick(32'd0);                                                 // dt always zero
		send_item(integ_beat(stamp_now + 10, 32'h0100_0000, 0, 0, 0));
		write_tick(32'hFFFF_FFFF);
		send_item(integ_beat(stamp_now + 11, 32'h0000_0100, 32'h0000_0200, 0, 0));
		write_tick(32'd1);
		send_item(integ_beat(stamp_now + 12, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0));
		stamp_now = stamp_now + 12;
	endtask

	function automatic logic [31:0] rand_rate();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(32'h0400_0000)) -
				$signed(32'h0200_0000);
		endcase
	endfunction

	task automatic test_random(input int count);
		in_item_t it;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0: it = set_beat($urandom, $urandom, $urandom, $urandom);
				1: begin
					it = integ_beat($urandom, rand_rate(), rand_rate(), rand_rate(), rand_rate());
					stamp_now = it.timestamp;
				end
				2: it = integ_beat(stamp_now - $urandom_range(1000), rand_rate(), rand_rate(),
					rand_rate(), rand_rate());
				default: begin
					stamp_now = stamp_now + $urandom_range(1, 2000);
					it = integ_beat(stamp_now, rand_rate(), rand_rate(), rand_rate(), rand_rate());
				end
			endcase
			if (it.func == 1'b0 && $urandom_range(2) != 0) stamp_now = it.timestamp;
			send_item(it);
		end
	endtask

	// Receiver holds off for a long stretch while beats keep coming.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(12);
		join
	endtask

	// Receiver: random stalls, check every accepted result against the oldest prediction.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat", 64'(out_data.status), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (out_data.quat_w !== want.quat_w)
					report_mismatch("quat_w", 64'(out_data.quat_w), 64'(want.quat_w));
				if (out_data.quat_x !== want.quat_x)
					report_mismatch("quat_x", 64'(out_data.quat_x), 64'(want.quat_x));
				if (out_data.quat_y !== want.quat_y)
					report_mismatch("quat_y", 64'(out_data.quat_y), 64'(want.quat_y));
				if (out_data.quat_z !== want.quat_z)
					report_mismatch("quat_z", 64'(out_data.quat_z), 64'(want.quat_z));
				if (out_data.status !== want.status)
					report_mismatch("status", 64'(out_data.status), 64'(want.status));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		hold_off = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 53;
		tick_period = TICK_RESET;
		att[0] = 64'sd1 << 30; att[1] = 0; att[2] = 0; att[3] = 0;
		prev_stamp = 0;
		stamp_seen = 1'b0;
		stamp_now = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_tick_period();
		write_tick(TICK_RESET);
		test_random(250);
		test_backpressure();
		send_idle_pct = 53;
		recv_idle_pct = 17;
		write_tick(32'd100_000);
		test_random(240);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tick(32'd4295);
		test_random(240);
		drain();

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
